// ===== rtl/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, codes and calendar helpers for the date arithmetic core.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

  typedef enum logic [2:0] {
    OP_NEXT_DAY = 3'd0,
    OP_PREV_DAY = 3'd1,
    OP_WEEK     = 3'd2,
    OP_ANNIV    = 3'd3,
    OP_DURATION = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_WALK  = 3'd2,
    ST_YEAR  = 3'd3,
    ST_FIN   = 3'd4,
    ST_OUT   = 3'd5
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [15:0] first_year;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [15:0] second_year;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [15:0] out_year;
    logic [24:0] count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic walk;
    logic year;
    logic fin;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
  } dp_sts_t;

  localparam int unsigned WalkSteps = 12;

  // floor(x / 25) by reciprocal multiply, exact for any 16-bit x
  function automatic logic [11:0] div25(input logic [15:0] x);
    logic [32:0] p;
    begin
      p     = 33'(x) * 33'd83887;
      div25 = p[32:21];
    end
  endfunction

  // divisible by 100 = divisible by 4 and 25; by 400 = by 16 and 25
  function automatic logic is_leap(input logic [15:0] y);
    logic [11:0] q;
    logic        d25;
    begin
      q       = div25(y);
      d25     = (({4'd0, q} * 16'd25) == y);
      is_leap = (y[1:0] == 2'b00) && (!d25 || (y[3:0] == 4'd0));
    end
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    begin
      case (m)
        4'd2:                         days_in = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:      days_in = 5'd30;
        default:                      days_in = 5'd31;
      endcase
    end
  endfunction

  function automatic logic [3:0] fix_month(input logic [3:0] m);
    begin
      if (m == 4'd0) fix_month = 4'd1;
      else if (m > 4'd12) fix_month = 4'd12;
      else fix_month = m;
    end
  endfunction

  function automatic logic [4:0] fix_day(input logic [4:0] d, input logic [3:0] m,
                                         input logic leap);
    logic [4:0] lim;
    begin
      lim = days_in(m, leap);
      if (d == 5'd0) fix_day = 5'd1;
      else if (d > lim) fix_day = lim;
      else fix_day = d;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gda_if.sv =====
// ----------------------------------------------------------------------------
// gda_in_if / gda_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface gda_in_if;
  logic             valid;
  logic             ready;
  gda_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gda_out_if;
  logic              valid;
  logic              ready;
  gda_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gregorian_date_arithmetic_core.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core
// Gregorian date unit: next/previous day, week number, days to anniversary,
// day distance.
// ----------------------------------------------------------------------------
// Sequence: the item is loaded at the accepting edge, then runs through the
// month walk, the year span and the finish; the result is then held until taken.
// One item at a time: no new item is accepted while one is in flight or its
// result is pending.
// Reset: synchronous active-low rst_n returns the sequencer to idle.
`default_nettype none

module gregorian_date_arithmetic_core (
  input wire logic  clk,
  input wire logic  rst_n,
  gda_in_if.sink    in_ch,
  gda_out_if.source out_ch
);

  gda_pkg::dp_cmd_t cmd;
  gda_pkg::dp_sts_t sts;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gda_dp u_dp (
    .clk      (clk),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_ch.data)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.walk, cmd.year, cmd.fin}) <= 1)
    else $error("more than one datapath command");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while result pending");

  a_fin_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_ch.valid)
    else $error("result not presented after finish");

endmodule

`default_nettype wire

// ===== rtl/gda_ctrl.sv =====
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer: load on accept, month walk, year-span step, finish, hold result.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output gda_pkg::dp_cmd_t      cmd,
  input  wire gda_pkg::dp_sts_t sts
);

  gda_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gda_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      gda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // capture the item at the accepting edge
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = gda_pkg::ST_WALK;
        end
      end
      gda_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = gda_pkg::ST_YEAR;
      end
      gda_pkg::ST_YEAR: begin
        cmd.year  = 1'b1;
        state_nxt = gda_pkg::ST_FIN;
      end
      gda_pkg::ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = gda_pkg::ST_OUT;
      end
      gda_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = gda_pkg::ST_IDLE;
      end
      default: state_nxt = gda_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gda_dp.sv =====
// ----------------------------------------------------------------------------
// gda_dp
// Datapath: normalizes the dates, walks months to accumulate day-of-year
// sums, builds year offsets and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_dp (
  input  wire logic              clk,
  input  wire gda_pkg::in_item_t in_data,
  input  wire gda_pkg::dp_cmd_t  cmd,
  output gda_pkg::dp_sts_t       sts,
  output gda_pkg::out_item_t     out_data
);

  logic [2:0]  op_r;
  logic [4:0]  d1_r, d2_r, bd_r;
  logic [3:0]  m1_r, m2_r, bm_r;
  logic [15:0] y1_r, y2_r;
  logic        l1_r, l2_r, ln_r;
  logic [3:0]  mi_r;               // walk month, 1..12
  logic [8:0]  s1_r, s2_r, sb1_r, sbn_r;  // days before month in each walk
  logic [24:0] ys1_r, ys2_r;
  gda_pkg::out_item_t res_r;
  gda_pkg::out_item_t res_nxt;
  logic [24:0] abs1, abs2;

  // load-stage normalization
  logic [15:0] y1_in, y2_in;
  logic        l1_in, l2_in;
  logic [3:0]  m1_in, m2_in;
  always_comb begin
    y1_in = in_data.first_year;
    y2_in = in_data.second_year;
    l1_in = gda_pkg::is_leap(y1_in);
    l2_in = gda_pkg::is_leap(y2_in);
    m1_in = gda_pkg::fix_month(in_data.first_month);
    m2_in = gda_pkg::fix_month(in_data.second_month);
  end

  // year start: 365*y + leaps; /100 and /400 as /4 or /16 then /25
  function automatic logic [24:0] year_start(input logic [15:0] y);
    logic [16:0] y3;
    logic [16:0] y99;
    logic [16:0] y399;
    logic [11:0] c100;
    logic [11:0] c400;
    logic [24:0] lp;
    begin
      y3   = {1'b0, y} + 17'd3;
      y99  = {1'b0, y} + 17'd99;
      y399 = {1'b0, y} + 17'd399;
      c100 = gda_pkg::div25({1'b0, y99[16:2]});
      c400 = gda_pkg::div25({3'd0, y399[16:4]});
      lp   = {10'd0, y3[16:2]} - {13'd0, c100} + {13'd0, c400};
      year_start = 25'(y) * 25'd365 + lp;
    end
  endfunction

  logic walk_last;
  assign walk_last  = (mi_r == 4'(gda_pkg::WalkSteps));
  assign sts.walk_done = walk_last;

  always_comb begin
    res_nxt = '0;
    abs1    = ys1_r + 25'(s1_r) + 25'(d1_r);
    abs2    = ys2_r + 25'(s2_r) + 25'(d2_r);
    case (op_r)
      gda_pkg::OP_NEXT_DAY: begin
        if (d1_r < gda_pkg::days_in(m1_r, l1_r)) begin
          res_nxt.out_day = d1_r + 5'd1; res_nxt.out_month = m1_r;
          res_nxt.out_year = y1_r;
        end else if (m1_r == 4'd12) begin
          res_nxt.out_day = 5'd1; res_nxt.out_month = 4'd1;
          res_nxt.out_year = y1_r + 16'd1;
        end else begin
          res_nxt.out_day = 5'd1; res_nxt.out_month = m1_r + 4'd1;
          res_nxt.out_year = y1_r;
        end
      end
      gda_pkg::OP_PREV_DAY: begin
        if (d1_r > 5'd1) begin
          res_nxt.out_day = d1_r - 5'd1; res_nxt.out_month = m1_r;
          res_nxt.out_year = y1_r;
        end else if (m1_r == 4'd1) begin
          res_nxt.out_day = 5'd31; res_nxt.out_month = 4'd12;
          res_nxt.out_year = y1_r - 16'd1;
        end else begin
          res_nxt.out_month = m1_r - 4'd1;
          res_nxt.out_day   = gda_pkg::days_in(m1_r - 4'd1, l1_r);
          res_nxt.out_year  = y1_r;
        end
      end
      gda_pkg::OP_WEEK: begin
        // (doy-1)/7+1 with doy-1 = s1 + d1 - 1 < 366
        res_nxt.count = 25'((20'(s1_r + 9'(d1_r) - 9'd1) * 20'd293) >> 11) + 25'd1;
      end
      gda_pkg::OP_ANNIV: begin
        if (bm_r > m1_r || (bm_r == m1_r && bd_r > d1_r))
          res_nxt.count = 25'((sb1_r + 9'(bd_r)) - (s1_r + 9'(d1_r)));
        else
          res_nxt.count = 25'((l1_r ? 10'd366 : 10'd365) - 10'(s1_r) - 10'(d1_r)
                              + 10'(sbn_r) + 10'(bd_r));
      end
      gda_pkg::OP_DURATION: begin
        if (abs1 > abs2) res_nxt.count = abs1 - abs2;
        else res_nxt.count = abs2 - abs1;
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      y1_r  <= y1_in;
      y2_r  <= y2_in;
      l1_r  <= l1_in;
      l2_r  <= l2_in;
      ln_r  <= gda_pkg::is_leap(y1_in + 16'd1);
      m1_r  <= m1_in;
      m2_r  <= m2_in;
      bm_r  <= m2_in;
      d1_r  <= gda_pkg::fix_day(in_data.first_day, m1_in, l1_in);
      d2_r  <= gda_pkg::fix_day(in_data.second_day, m2_in, l2_in);
      bd_r  <= gda_pkg::fix_day(in_data.second_day, m2_in, 1'b1);
      mi_r  <= 4'd1;
      s1_r  <= '0;
      s2_r  <= '0;
      sb1_r <= '0;
      sbn_r <= '0;
    end else if (cmd.walk && !walk_last) begin
      // one month a cycle: add its length where it lies before the target month
      if (mi_r < m1_r) s1_r  <= s1_r  + 9'(gda_pkg::days_in(mi_r, l1_r));
      if (mi_r < m2_r) s2_r  <= s2_r  + 9'(gda_pkg::days_in(mi_r, l2_r));
      if (mi_r < bm_r) begin
        sb1_r <= sb1_r + 9'(gda_pkg::days_in(mi_r, l1_r));
        sbn_r <= sbn_r + 9'(gda_pkg::days_in(mi_r, ln_r));
      end
      mi_r <= mi_r + 4'd1;
    end
    if (cmd.year) begin
      ys1_r <= year_start(y1_r);
      ys2_r <= year_start(y2_r);
    end
    if (cmd.fin) res_r <= res_nxt;
  end

  assign out_data = res_r;

endmodule

`default_nettype wire
